// File: design/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types, constants and the exponential table entry function for the softmax block.
// ----------------------------------------------------------------------------
package smv_pkg;

  localparam int unsigned MaxLenDefault   = 64;
  localparam int unsigned ExpDepthDefault = 256;
  localparam int unsigned ScoreW          = 16;
  localparam int unsigned ProbW           = 16;
  localparam int unsigned SumW            = 23;
  localparam int unsigned QueueDepth      = 2;
  localparam logic [31:0] ExpStepQ32      = 32'd4034748382;

  // front-to-back command
  typedef struct packed {
    logic [6:0] count;
    logic       dropped;
    logic [15:0] max_val;
  } smv_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXP,
    BK_DIV_START,
    BK_DIV,
    BK_EMIT
  } smv_bk_state_e;

  // table entry k, built by repeated multiply
  function automatic logic [15:0] exp_entry(input int unsigned k);
    logic [63:0] acc;
    logic [63:0] q16;
    acc = 64'd1 << 32;
    for (int unsigned j = 0; j < k; j++) begin
      acc = (acc * {32'd0, ExpStepQ32} + 64'h8000_0000) >> 32;
    end
    q16 = (acc + 64'h8000) >> 16;
    return (q16 > 64'd65535) ? 16'hFFFF : q16[15:0];
  endfunction

endpackage

// File: design/smv_ram.sv
// ----------------------------------------------------------------------------
// smv_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module smv_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/smv_front.sv
// ----------------------------------------------------------------------------
// smv_front
// Accepts score beats, writes the score store, tracks max, count and drop,
// and pushes one command per vector into the queue.
// ----------------------------------------------------------------------------
module smv_front #(
  parameter int unsigned MaxLen = smv_pkg::MaxLenDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [15:0]               score_i,
  input  logic                      final_element_i,
  output logic                      we_o,
  output logic [$clog2(MaxLen > 1 ? MaxLen : 2)-1:0] waddr_o,
  output logic                      push_o,
  output smv_pkg::smv_cmd_t         cmd_o
);
  import smv_pkg::*;

  localparam int unsigned AW = $clog2(MaxLen > 1 ? MaxLen : 2);

  logic [6:0]  count_q, count_d;
  logic [15:0] max_q, max_d;
  logic        drop_q, drop_d;
  logic        room;
  logic [15:0] new_max;

  assign room    = count_q < 7'(MaxLen);
  assign we_o    = accept_i && room;
  assign waddr_o = count_q[AW-1:0];
  assign new_max = ($signed(score_i) > $signed(max_q)) ? score_i : max_q;

  always_comb begin
    count_d = count_q;
    max_d   = max_q;
    drop_d  = drop_q;
    push_o  = 1'b0;
    cmd_o.count   = count_q;
    cmd_o.dropped = drop_q;
    cmd_o.max_val = max_q;
    if (accept_i) begin
      if (room) begin
        count_d       = count_q + 7'd1;
        max_d         = new_max;
        cmd_o.count   = count_q + 7'd1;
        cmd_o.max_val = new_max;
      end else begin
        drop_d        = 1'b1;
        cmd_o.dropped = 1'b1;
      end
      if (final_element_i) begin
        push_o  = 1'b1;
        count_d = '0;
        max_d   = 16'h8000;
        drop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_q   <= 16'h8000;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      max_q   <= max_d;
      drop_q  <= drop_d;
    end
  end

endmodule

// File: design/smv_back.sv
// ----------------------------------------------------------------------------
// smv_back
// Pops a vector command, looks up exp per stored score, sums, then divides
// each exp by the sum with a bit-serial divider and emits the probabilities.
// ----------------------------------------------------------------------------
module smv_back #(
  parameter int unsigned MaxLen   = smv_pkg::MaxLenDefault,
  parameter int unsigned ExpDepth = smv_pkg::ExpDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  smv_pkg::smv_cmd_t         cmd_i,
  output logic                      pop_o,
  output logic [$clog2(MaxLen > 1 ? MaxLen : 2)-1:0] raddr_o,
  input  logic [15:0]               score_rdata_i,
  output logic                      exp_we_o,
  output logic [$clog2(MaxLen > 1 ? MaxLen : 2)-1:0] exp_waddr_o,
  output logic [15:0]               exp_wdata_o,
  input  logic [15:0]               exp_rdata_i,
  output logic                      strobe_o,
  output logic [15:0]               probability_o,
  output logic                      run_end_o,
  output logic                      overflow_o,
  output logic                      active_o
);
  import smv_pkg::*;

  localparam int unsigned AW = $clog2(MaxLen > 1 ? MaxLen : 2);
  localparam int unsigned TW = $clog2(ExpDepth);
  localparam int unsigned NumW = 33;

  // whole exp table, packed, built once at elaboration
  function automatic logic [ExpDepth*16-1:0] build_rom();
    logic [ExpDepth*16-1:0] t;
    logic [63:0] acc;
    logic [63:0] q16;
    t   = '0;
    acc = 64'd1 << 32;
    for (int unsigned k = 0; k < ExpDepth; k++) begin
      q16 = (acc + 64'h8000) >> 16;
      t[k*16 +: 16] = (q16 > 64'd65535) ? 16'hFFFF : q16[15:0];
      acc = (acc * {32'd0, ExpStepQ32} + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam logic [ExpDepth*16-1:0] ExpRom = build_rom();

  smv_bk_state_e state_q, state_d;
  smv_cmd_t      cmd_q, cmd_d;
  logic [6:0]    rd_q, rd_d;
  logic [6:0]    wr_q, wr_d;
  logic          rv_q, rv_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic [16:0]   quo_q, quo_d;
  logic [5:0]    bit_q, bit_d;
  logic [31:0]   num_q, num_d;
  logic          sat_q, sat_d;
  logic [16:0]   diff;
  logic [15:0]   exp_val;
  logic [NumW-1:0] trial;

  // exp of (score - max), looked up by max - score
  always_comb begin
    diff = 17'($signed(cmd_q.max_val)) - 17'($signed(score_rdata_i));
    if (diff[16:4] >= 13'(ExpDepth)) begin
      exp_val = '0;
    end else begin
      exp_val = ExpRom[{diff[TW+3:4], 4'b0000} +: 16];
    end
  end

  assign raddr_o     = rd_q[AW-1:0];
  assign exp_waddr_o = wr_q[AW-1:0];
  assign exp_wdata_o = exp_val;
  assign active_o    = (state_q != BK_IDLE);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    rv_d     = 1'b0;
    sum_d    = sum_q;
    bit_d    = bit_q;
    pop_o    = 1'b0;
    exp_we_o = 1'b0;
    strobe_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          rd_d  = '0;
          wr_d  = '0;
          sum_d = '0;
          state_d = (cmd_i.count == '0) ? BK_IDLE : BK_EXP;
        end
      end
      BK_EXP: begin
        if (rd_q < cmd_q.count) begin
          rd_d = rd_q + 7'd1;
          rv_d = 1'b1;
        end
        if (rv_q) begin
          exp_we_o = 1'b1;
          sum_d    = sum_q + SumW'(exp_val);
          wr_d     = wr_q + 7'd1;
          if (wr_q + 7'd1 == cmd_q.count) begin
            rd_d    = '0;
            state_d = BK_DIV_START;
          end
        end
      end
      BK_DIV_START: begin
        // the read of rd_q is issued here; its data is loaded when BK_DIV begins
        bit_d   = 6'd32;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        // restoring division of exp<<16 by sum, one bit per cycle
        if (bit_q == 6'd32) begin
          bit_d = 6'd31;
        end else if (bit_q == 6'd0) begin
          state_d = BK_EMIT;
        end else begin
          bit_d = bit_q - 6'd1;
        end
      end
      BK_EMIT: begin
        strobe_o = 1'b1;
        rd_d     = rd_q + 7'd1;
        if (rd_q + 7'd1 == cmd_q.count) begin
          state_d = BK_IDLE;
        end else begin
          state_d = BK_DIV_START;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // the dividend bits are fed from a shift register loaded at the start
  assign trial = {rem_q[NumW-2:0], num_q[31]};

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    sat_d = sat_q;
    if (state_q == BK_DIV) begin
      if (bit_q == 6'd32) begin
        num_d = {exp_rdata_i, 16'd0};
        rem_d = '0;
        quo_d = '0;
        sat_d = 1'b0;
      end else begin
        num_d = {num_q[30:0], 1'b0};
        if (trial >= NumW'(sum_q)) begin
          rem_d = trial - NumW'(sum_q);
          quo_d = {quo_q[15:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[15:0], 1'b0};
        end
        if (quo_q[16]) begin
          sat_d = 1'b1;
        end
      end
    end
  end

  assign probability_o = (sum_q == '0 || sat_q || quo_q[16]) ? 16'hFFFF : quo_q[15:0];
  assign run_end_o     = (rd_q + 7'd1 == cmd_q.count);
  assign overflow_o    = cmd_q.dropped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      rd_q    <= '0;
      wr_q    <= '0;
      rv_q    <= 1'b0;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      rv_q    <= rv_d;
      cmd_q   <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    bit_q <= bit_d;
    num_q <= num_d;
    sat_q <= sat_d;
  end

endmodule

// File: design/smv_queue.sv
// ----------------------------------------------------------------------------
// smv_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module smv_queue #(
  parameter int unsigned Depth = smv_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  smv_pkg::smv_cmd_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output smv_pkg::smv_cmd_t data_o
);
  import smv_pkg::*;

  localparam int unsigned PW = $clog2(Depth);

  smv_cmd_t      buf_q [Depth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == (PW+1)'(Depth);
  assign data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(Depth-1)) ? '0 : wp_q + PW'(1);
      if (pop_i)  rp_q <= (rp_q == PW'(Depth-1)) ? '0 : rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= data_i;
  end

endmodule

// File: design/softmax_vector.sv
// ----------------------------------------------------------------------------
// softmax_vector
// Streaming softmax over signed Q8.8 scores with max subtraction.
// ----------------------------------------------------------------------------
// Scores are taken one per cycle while busy is low; up to MaxLen are kept
// and the rest are dropped and flagged. The element marked final queues the
// vector for the back end, which looks up exp for each stored score and sums
// the results, then divides each exp by the sum on the bit-serial divider,
// showing each probability for one cycle on result_valid_o. The receiver
// cannot stall. busy is high from the cycle after the final element until
// the back end has emitted the last probability of that vector.
// ----------------------------------------------------------------------------
module softmax_vector #(
  parameter int unsigned MaxLen   = smv_pkg::MaxLenDefault,
  parameter int unsigned ExpDepth = smv_pkg::ExpDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] score_i,
  input  logic        final_element_i,
  output logic        result_valid_o,
  output logic [15:0] probability_o,
  output logic        run_end_o,
  output logic        overflow_o
);
  import smv_pkg::*;

  localparam int unsigned AW = $clog2(MaxLen > 1 ? MaxLen : 2);

  logic          accept, we, push, pop, q_valid, q_full;
  logic [AW-1:0] waddr, raddr, exp_waddr;
  logic [15:0]   score_rdata, exp_rdata, exp_wdata;
  logic          exp_we;
  logic          back_active;
  smv_cmd_t      cmd_in, cmd_out;

  // the score store is shared, so the front waits until the back is done
  assign busy   = q_valid || q_full || back_active;
  assign accept = start && !busy;

  smv_front #(.MaxLen(MaxLen)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .score_i, .final_element_i,
    .we_o(we), .waddr_o(waddr), .push_o(push), .cmd_o(cmd_in)
  );

  smv_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd_in), .pop_i(pop),
    .valid_o(q_valid), .full_o(q_full), .data_o(cmd_out)
  );

  smv_ram #(.Width(ScoreW), .Depth(MaxLen > 1 ? MaxLen : 2)) u_score_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(score_i),
    .raddr_i(raddr), .rdata_o(score_rdata)
  );

  smv_ram #(.Width(ProbW), .Depth(MaxLen > 1 ? MaxLen : 2)) u_exp_ram (
    .clk_i, .we_i(exp_we), .waddr_i(exp_waddr), .wdata_i(exp_wdata),
    .raddr_i(raddr), .rdata_o(exp_rdata)
  );

  smv_back #(.MaxLen(MaxLen), .ExpDepth(ExpDepth)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(cmd_out), .pop_o(pop),
    .raddr_o(raddr), .score_rdata_i(score_rdata),
    .exp_we_o(exp_we), .exp_waddr_o(exp_waddr), .exp_wdata_o(exp_wdata),
    .exp_rdata_i(exp_rdata), .strobe_o(result_valid_o),
    .probability_o, .run_end_o, .overflow_o, .active_o(back_active)
  );

endmodule
